// ===== hdl/sccb_register_write_master_defines.svh =====
// ----------------------------------------------------------------------------
// sccb write master assertion macros
// shared property shapes for the checker, clocked on clk, off during rst
// ----------------------------------------------------------------------------
`ifndef SCCB_REGISTER_WRITE_MASTER_DEFINES_SVH
`define SCCB_REGISTER_WRITE_MASTER_DEFINES_SVH

// condition holds in the same cycle
`define SCCB_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sccb write master check failed");

// condition holds in the next cycle
`define SCCB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sccb write master check failed");

`endif

// ===== hdl/sccb_wm_pkg.sv =====
// ----------------------------------------------------------------------------
// sccb write master package
// shared types, register indexes and reset values
// ----------------------------------------------------------------------------
package sccb_wm_pkg;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 24;

  localparam logic [CFG_INDEX_W-1:0] REG_DEVICE_ADDRESS = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PHASE_TICKS    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_GAP_TICKS      = 2'd2;

  localparam logic [7:0]  DEVICE_ADDRESS_RST = 8'h78;
  localparam logic [15:0] PHASE_TICKS_RST    = 16'd1000;
  localparam logic [23:0] GAP_TICKS_RST      = 24'd200000;

  localparam logic [3:0] BIT_LAST  = 4'd8;
  localparam logic [1:0] BYTE_LAST = 2'd3;
  localparam logic [3:0] PINS_IDLE = 4'hF;

  typedef struct packed {
    logic [7:0]  device_address;
    logic [15:0] phase_ticks;
    logic [23:0] gap_ticks;
  } cfg_t;

  typedef struct packed {
    logic        action;
    logic        camera;
    logic [15:0] reg_addr;
    logic [7:0]  write_data;
  } req_t;

  typedef struct packed {
    logic left_clock;
    logic left_data;
    logic right_clock;
    logic right_data;
    logic busy_res;
    logic done_res;
  } res_t;

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_START1 = 9'b000000010,
    ST_START2 = 9'b000000100,
    ST_START3 = 9'b000001000,
    ST_BYTE   = 9'b000010000,
    ST_STOP1  = 9'b000100000,
    ST_STOP2  = 9'b001000000,
    ST_STOP3  = 9'b010000000,
    ST_GAP    = 9'b100000000
  } state_t;

  typedef enum logic [1:0] {
    SUB_DATA = 2'd0,
    SUB_HIGH = 2'd1,
    SUB_LOW  = 2'd2
  } sub_t;

endpackage

// ===== hdl/sccb_register_write_master.sv =====
// ----------------------------------------------------------------------------
// sccb register write master
// bit-timed write master for two camera buses, one beat in, one beat out
// ----------------------------------------------------------------------------
//  channel   signals                                   direction
//  input     in_valid/in_ready, action, camera,        in
//            reg_addr, write_data
//  result    out_valid/out_ready, left_clock,          out
//            left_data, right_clock, right_data,
//            busy_res, done_res
//  config    cfg_write, cfg_index, cfg_data            in
//
//  one beat per cycle sustained unless the result stalls; a beat reaches
//  the result port via the input register, then the step logic into the
//  result register. the step counter compare and pin update are combinational.
//  rst is synchronous and clears sequencer, counters and pins (all high).
//  a stalled result holds the step logic; the input register takes one more.
// ----------------------------------------------------------------------------
module sccb_register_write_master (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                action,
  input  logic                                camera,
  input  logic [15:0]                         reg_addr,
  input  logic [7:0]                          write_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                left_clock,
  output logic                                left_data,
  output logic                                right_clock,
  output logic                                right_data,
  output logic                                busy_res,
  output logic                                done_res,
  input  logic                                cfg_write,
  input  logic [sccb_wm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sccb_wm_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import sccb_wm_pkg::*;

  cfg_t cfg;
  req_t in_item;
  req_t s1_item;
  res_t out_item;
  logic s1_valid;
  logic s1_ready;

  assign in_item.action     = action;
  assign in_item.camera     = camera;
  assign in_item.reg_addr   = reg_addr;
  assign in_item.write_data = write_data;

  sccb_wm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  sccb_wm_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .s1_valid (s1_valid),
    .s1_ready (s1_ready),
    .s1_item  (s1_item)
  );

  sccb_wm_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .s1_valid  (s1_valid),
    .s1_ready  (s1_ready),
    .s1_item   (s1_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  assign left_clock  = out_item.left_clock;
  assign left_data   = out_item.left_data;
  assign right_clock = out_item.right_clock;
  assign right_data  = out_item.right_data;
  assign busy_res    = out_item.busy_res;
  assign done_res    = out_item.done_res;

endmodule

// ===== hdl/sccb_wm_cfg.sv =====
// ----------------------------------------------------------------------------
// sccb write master configuration registers
// device address, step length and settling gap, written by index
// ----------------------------------------------------------------------------
module sccb_wm_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [sccb_wm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sccb_wm_pkg::CFG_DATA_W-1:0]  cfg_data,
  output sccb_wm_pkg::cfg_t                   cfg
);
  import sccb_wm_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.device_address <= DEVICE_ADDRESS_RST;
      cfg.phase_ticks    <= PHASE_TICKS_RST;
      cfg.gap_ticks      <= GAP_TICKS_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_DEVICE_ADDRESS: cfg.device_address <= cfg_data[7:0];
        REG_PHASE_TICKS:    cfg.phase_ticks    <= cfg_data[15:0];
        REG_GAP_TICKS:      cfg.gap_ticks      <= cfg_data[23:0];
        default:            ;
      endcase
    end
  end

endmodule

// ===== hdl/sccb_wm_in_reg.sv =====
// ----------------------------------------------------------------------------
// sccb write master input register
// holds one request or tick beat in front of the step logic
// ----------------------------------------------------------------------------
module sccb_wm_in_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  sccb_wm_pkg::req_t  in_item,
  output logic               s1_valid,
  input  logic               s1_ready,
  output sccb_wm_pkg::req_t  s1_item
);
  import sccb_wm_pkg::*;

  assign in_ready = !s1_valid || s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item <= in_item;
    end
  end

endmodule

// ===== hdl/sccb_wm_core.sv =====
// ----------------------------------------------------------------------------
// sccb write master step logic
// sequencer state, tick counter, shift byte and the result register
// ----------------------------------------------------------------------------
module sccb_wm_core (
  input  logic               clk,
  input  logic               rst,
  input  sccb_wm_pkg::cfg_t  cfg,
  input  logic               s1_valid,
  output logic               s1_ready,
  input  sccb_wm_pkg::req_t  s1_item,
  output logic               out_valid,
  input  logic               out_ready,
  output sccb_wm_pkg::res_t  out_item
);
  import sccb_wm_pkg::*;

  state_t      state, state_next;
  sub_t        sub, sub_next;
  logic [3:0]  bit_idx, bit_idx_next;
  logic [1:0]  which, which_next;
  logic [23:0] tick, tick_next;
  logic [23:0] tick_inc;
  logic [7:0]  shift, shift_next;
  logic [23:0] req, req_next;
  logic        bus, bus_next;
  logic        busy, busy_next;
  logic [3:0]  pins, pins_next;
  logic        done;
  logic        enter;
  logic        fire;
  logic        clk_cur, dat_cur, clk_n, dat_n;
  logic [7:0]  load_byte;

  assign s1_ready = !out_valid || out_ready;
  assign fire     = s1_valid && s1_ready;
  assign tick_inc = tick + 24'd1;

  // sequencer and counters
  always_comb begin
    state_next   = state;
    sub_next     = sub;
    bit_idx_next = bit_idx;
    which_next   = which;
    tick_next    = tick;
    req_next     = req;
    bus_next     = bus;
    busy_next    = busy;
    done         = 1'b0;
    enter        = 1'b0;
    if (s1_item.action) begin
      if (!busy) begin
        bus_next   = s1_item.camera;
        req_next   = {s1_item.reg_addr, s1_item.write_data};
        busy_next  = 1'b1;
        state_next = ST_START1;
        tick_next  = '0;
        enter      = 1'b1;
      end
    end else if (busy) begin
      tick_next = tick_inc;
      if (state == ST_GAP) begin
        if (tick_inc >= cfg.gap_ticks) begin
          busy_next  = 1'b0;
          state_next = ST_IDLE;
          tick_next  = '0;
          done       = 1'b1;
        end
      end else if (tick_inc >= {8'd0, cfg.phase_ticks}) begin
        tick_next = '0;
        enter     = 1'b1;
        unique case (state)
          ST_START1: state_next = ST_START2;
          ST_START2: state_next = ST_START3;
          ST_START3: begin
            state_next   = ST_BYTE;
            which_next   = '0;
            bit_idx_next = '0;
            sub_next     = SUB_DATA;
          end
          ST_BYTE: begin
            unique case (sub)
              SUB_DATA: sub_next = SUB_HIGH;
              SUB_HIGH: sub_next = SUB_LOW;
              default: begin
                sub_next = SUB_DATA;
                if (bit_idx == BIT_LAST) begin
                  bit_idx_next = '0;
                  if (which == BYTE_LAST) begin
                    state_next = ST_STOP1;
                  end else begin
                    which_next = which + 2'd1;
                  end
                end else begin
                  bit_idx_next = bit_idx + 4'd1;
                end
              end
            endcase
          end
          ST_STOP1: state_next = ST_STOP2;
          ST_STOP2: state_next = ST_STOP3;
          ST_STOP3: state_next = ST_GAP;
          default:  state_next = state;
        endcase
      end
    end
  end

  // pin levels for the step being entered
  always_comb begin
    unique case (which_next)
      2'd0:    load_byte = cfg.device_address;
      2'd1:    load_byte = req_next[23:16];
      2'd2:    load_byte = req_next[15:8];
      default: load_byte = req_next[7:0];
    endcase
    clk_cur    = bus_next ? pins[1] : pins[3];
    dat_cur    = bus_next ? pins[0] : pins[2];
    clk_n      = clk_cur;
    dat_n      = dat_cur;
    shift_next = shift;
    if (enter) begin
      unique case (state_next)
        ST_START1: begin
          clk_n = 1'b1;
          dat_n = 1'b1;
        end
        ST_START2: dat_n = 1'b0;
        ST_START3: clk_n = 1'b0;
        ST_BYTE: begin
          unique case (sub_next)
            SUB_DATA: begin
              if (bit_idx_next == '0) begin
                shift_next = load_byte;
              end
              dat_n = (bit_idx_next == BIT_LAST) ? 1'b0 : shift_next[7];
            end
            SUB_HIGH: clk_n = 1'b1;
            default: begin
              clk_n = 1'b0;
              if (bit_idx_next != BIT_LAST) begin
                shift_next = {shift[6:0], 1'b0};
              end
            end
          endcase
        end
        ST_STOP1: dat_n = 1'b0;
        ST_STOP2: clk_n = 1'b1;
        ST_STOP3: dat_n = 1'b1;
        default:  ;
      endcase
      pins_next = bus_next ? {2'b11, clk_n, dat_n} : {clk_n, dat_n, 2'b11};
    end else begin
      pins_next = pins;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      sub     <= SUB_DATA;
      bit_idx <= '0;
      which   <= '0;
      tick    <= '0;
      shift   <= '0;
      req     <= '0;
      bus     <= 1'b0;
      busy    <= 1'b0;
      pins    <= PINS_IDLE;
    end else if (fire) begin
      state   <= state_next;
      sub     <= sub_next;
      bit_idx <= bit_idx_next;
      which   <= which_next;
      tick    <= tick_next;
      shift   <= shift_next;
      req     <= req_next;
      bus     <= bus_next;
      busy    <= busy_next;
      pins    <= pins_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_item.left_clock  <= pins_next[3];
      out_item.left_data   <= pins_next[2];
      out_item.right_clock <= pins_next[1];
      out_item.right_data  <= pins_next[0];
      out_item.busy_res    <= busy_next;
      out_item.done_res    <= done;
    end
  end

endmodule

// ===== hdl/sccb_wm_checker.sv =====
// ----------------------------------------------------------------------------
// sccb write master port checker
// pin and status relations seen on the result port
// ----------------------------------------------------------------------------
`include "sccb_register_write_master_defines.svh"

module sccb_wm_checker (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_ready,
  input logic left_clock,
  input logic left_data,
  input logic right_clock,
  input logic right_data,
  input logic busy_res,
  input logic done_res
);

  `SCCB_ASSERT_NOW(a_done_not_busy, out_valid && done_res, !busy_res)
  `SCCB_ASSERT_NOW(a_one_bus_idle, out_valid, (left_clock && left_data) || (right_clock && right_data))
  `SCCB_ASSERT_NOW(a_idle_pins_high, out_valid && !busy_res, left_clock && left_data && right_clock && right_data)
  `SCCB_ASSERT_NEXT(a_stall_holds, out_valid && !out_ready, out_valid && $stable(busy_res) && $stable(done_res))

endmodule

bind sccb_register_write_master sccb_wm_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .left_clock  (left_clock),
  .left_data   (left_data),
  .right_clock (right_clock),
  .right_data  (right_data),
  .busy_res    (busy_res),
  .done_res    (done_res)
);
